>>> hw/rtl/revb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// revb_pkg: shared types, constants and helpers of the stereo reverb
// Delay line layout, fixed-point helpers, frame and control structs.
// ----------------------------------------------------------------------------
package revb_pkg;

	// Delay store geometry (comb lines left then right, allpass likewise)
	localparam int COMB_DEPTH = 22232;
	localparam int AP_DEPTH   = 3218;
	localparam int COMB_AW    = 15;
	localparam int AP_AW      = 12;
	localparam int CPOS_W     = 11;
	localparam int APOS_W     = 10;

	localparam logic [COMB_AW-1:0] COMB_BASE [16] = '{
		15'd0,     15'd1116,  15'd2304,  15'd3581,
		15'd4937,  15'd6359,  15'd7850,  15'd9407,
		15'd11024, 15'd12163, 15'd13374, 15'd14674,
		15'd16053, 15'd17498, 15'd19012, 15'd20592
	};
	localparam logic [CPOS_W-1:0] COMB_LEN [16] = '{
		11'd1116, 11'd1188, 11'd1277, 11'd1356,
		11'd1422, 11'd1491, 11'd1557, 11'd1617,
		11'd1139, 11'd1211, 11'd1300, 11'd1379,
		11'd1445, 11'd1514, 11'd1580, 11'd1640
	};
	localparam logic [AP_AW-1:0] AP_BASE [8] = '{
		12'd0, 12'd556, 12'd997, 12'd1338,
		12'd1563, 12'd2142, 12'd2606, 12'd2970
	};
	localparam logic [APOS_W-1:0] AP_LEN [8] = '{
		10'd556, 10'd441, 10'd341, 10'd225,
		10'd579, 10'd464, 10'd364, 10'd248
	};

	// Fixed-point constants
	localparam logic [16:0] ONE_Q16    = 17'd65536;
	localparam logic [15:0] FB_BASE    = 16'd45875;
	localparam logic [14:0] FB_ROOM    = 15'd18350;
	localparam logic [14:0] DAMP_SCALE = 15'd26214;
	localparam logic [16:0] IN_GAIN    = 17'd125829;

	// Register reset values
	localparam logic [16:0] RST_ROOM  = 17'd32768;
	localparam logic [16:0] RST_DAMP  = 17'd32768;
	localparam logic [16:0] RST_WIDTH = 17'd65536;
	localparam logic [16:0] RST_MIX   = 17'd19661;
	localparam logic [23:0] RST_COEF  = 24'd34917;

	localparam logic signed [59:0] S32_MAX = 60'sd2147483647;
	localparam logic signed [59:0] S32_MIN = -60'sd2147483648;
	localparam logic signed [59:0] S24_MAX = 60'sd8388607;
	localparam logic signed [59:0] S24_MIN = -60'sd8388608;

	// Register indexes
	typedef enum logic [2:0] {
		CFG_ROOM  = 3'd0,
		CFG_DAMP  = 3'd1,
		CFG_WIDTH = 3'd2,
		CFG_MIX   = 3'd3,
		CFG_COEF  = 3'd4
	} revb_cfg_idx_t;

	typedef struct packed {
		logic signed [23:0] left_in;
		logic signed [23:0] right_in;
	} revb_in_t;

	typedef struct packed {
		logic signed [23:0] left_out;
		logic signed [23:0] right_out;
	} revb_out_t;

	typedef struct packed {
		logic [16:0] room;
		logic [16:0] damp;
		logic [16:0] width;
		logic [16:0] mix;
		logic [23:0] coef;
	} revb_cfg_t;

	typedef struct packed {
		logic ready;
		logic res_valid;
	} revb_stat_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE,
		ST_SM_MUL, ST_SM_ADD,
		ST_FB_MUL, ST_FB_SET, ST_D_SET, ST_MONO_SET,
		ST_CB_RD, ST_CB_M1, ST_CB_M2, ST_CB_LP, ST_CB_M3, ST_CB_WR,
		ST_AP_RD, ST_AP_WR,
		ST_WD_1, ST_WD_2, ST_WD_3, ST_WD_4, ST_WD_5,
		ST_WD_6, ST_WD_7, ST_WD_8, ST_WD_9,
		ST_DONE
	} revb_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
		if (v > S32_MAX) return 32'sh7FFFFFFF;
		else if (v < S32_MIN) return 32'sh80000000;
		else return 32'(v);
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [59:0] v);
		if (v > S24_MAX) return 24'sh7FFFFF;
		else if (v < S24_MIN) return 24'sh800000;
		else return 24'(v);
	endfunction

	// Round half up, then arithmetic shift
	function automatic logic signed [59:0] rnd16(input logic signed [59:0] v);
		return (v + 60'sd32768) >>> 16;
	endfunction

	function automatic logic signed [59:0] rnd17(input logic signed [59:0] v);
		return (v + 60'sd65536) >>> 17;
	endfunction

	function automatic logic signed [59:0] rnd24(input logic signed [59:0] v);
		return (v + 60'sd8388608) >>> 24;
	endfunction

	// Q1.16 register write from the low 17 bits, saturated to one
	function automatic logic [16:0] clamp_one(input logic [23:0] v);
		if (v[16:0] > ONE_Q16) return ONE_Q16;
		else return v[16:0];
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/revb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// revb_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module revb_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/revb_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// revb_core: frame sequencer and datapath
// Walks the smoother, 16 comb lines and 8 allpass lines through two delay
// RAMs with one shared registered multiplier, then mixes width and dry/wet.
// ----------------------------------------------------------------------------
module revb_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire revb_pkg::revb_in_t   frame,
	input  wire revb_pkg::revb_cfg_t  cfg,
	input  wire logic                 take,
	output revb_pkg::revb_stat_t      stat,
	output revb_pkg::revb_out_t       result
);

	revb_pkg::revb_state_t state_q, state_d;

	logic [revb_pkg::COMB_AW-1:0] clr_q;
	logic [1:0] sm_q;
	logic [3:0] cb_q;
	logic [2:0] ap_q;
	logic       first_q;

	logic [16:0]                       sm_val_q [4];
	logic signed [31:0]                lp_q     [16];
	logic [revb_pkg::CPOS_W-1:0]       cpos_q   [16];
	logic [revb_pkg::APOS_W-1:0]       apos_q   [8];

	logic signed [23:0] l_q, r_q;
	logic [16:0]        fb_q;
	logic [14:0]        d_q;
	logic signed [17:0] mono_q;
	logic signed [34:0] sum_l_q, sum_r_q;
	logic signed [31:0] al_q, ar_q, wl_q, wr_q;
	logic signed [23:0] ol_q, or_q;
	logic signed [57:0] acc_q, prod_q;
	logic [revb_pkg::COMB_AW-1:0] caddr_q;
	logic [revb_pkg::AP_AW-1:0]   aaddr_q;

	// shared multiplier operands
	logic signed [32:0] mul_a;
	logic signed [24:0] mul_b;

	logic                         clearing;
	logic [16:0]                  tgt;
	logic signed [17:0]           diff;
	logic signed [24:0]           lr;
	logic [revb_pkg::COMB_AW-1:0] cb_addr;
	logic [revb_pkg::AP_AW-1:0]   ap_addr;
	logic [revb_pkg::CPOS_W-1:0]  cpos_inc;
	logic [revb_pkg::APOS_W-1:0]  apos_inc;
	logic signed [59:0]           mac_sum;
	logic [17:0]                  wp;
	logic [16:0]                  wm, mm, one_m_d;

	logic                         c_we, a_we;
	logic [revb_pkg::COMB_AW-1:0] c_waddr;
	logic [revb_pkg::AP_AW-1:0]   a_waddr;
	logic [31:0]                  c_wdata, a_wdata, c_rdata, a_rdata;
	logic signed [31:0]           ap_x, ap_y;

	// delay stores
	revb_ram #(.DEPTH(revb_pkg::COMB_DEPTH), .WIDTH(32)) u_comb_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (cb_addr),
		.rdata (c_rdata)
	);

	revb_ram #(.DEPTH(revb_pkg::AP_DEPTH), .WIDTH(32)) u_ap_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (ap_addr),
		.rdata (a_rdata)
	);

	// address and small helpers
	always_comb begin
		clearing = (state_q == revb_pkg::ST_CLEAR);
		case (sm_q)
			2'd0:    tgt = cfg.room;
			2'd1:    tgt = cfg.damp;
			2'd2:    tgt = cfg.width;
			default: tgt = cfg.mix;
		endcase
		diff     = $signed({1'b0, tgt}) - $signed({1'b0, sm_val_q[sm_q]});
		lr       = 25'(l_q) + 25'(r_q);
		cb_addr  = revb_pkg::COMB_BASE[cb_q] + 15'(cpos_q[cb_q]);
		ap_addr  = revb_pkg::AP_BASE[ap_q] + 12'(apos_q[ap_q]);
		cpos_inc = cpos_q[cb_q] + 11'd1;
		apos_inc = apos_q[ap_q] + 10'd1;
		mac_sum  = 60'(acc_q) + 60'(prod_q);
		wp       = 18'(revb_pkg::ONE_Q16) + 18'(sm_val_q[2]);
		wm       = revb_pkg::ONE_Q16 - sm_val_q[2];
		mm       = revb_pkg::ONE_Q16 - sm_val_q[3];
		one_m_d  = revb_pkg::ONE_Q16 - 17'(d_q);
		ap_x     = ap_q[2] ? ar_q : al_q;
		ap_y     = revb_pkg::sat32(60'($signed(a_rdata)) - 60'(ap_x));
	end

	// RAM write ports: clearing sweep or write-back
	always_comb begin
		c_we    = clearing || (state_q == revb_pkg::ST_CB_WR);
		c_waddr = clearing ? clr_q : caddr_q;
		c_wdata = clearing ? 32'd0
			: revb_pkg::sat32(60'(mono_q) + revb_pkg::rnd16(60'(prod_q)));
		a_we    = (clearing && (clr_q < 15'(revb_pkg::AP_DEPTH)))
			|| (state_q == revb_pkg::ST_AP_WR);
		a_waddr = clearing ? clr_q[revb_pkg::AP_AW-1:0] : aaddr_q;
		a_wdata = clearing ? 32'd0
			: revb_pkg::sat32(60'(ap_x) + ((60'($signed(a_rdata)) + 60'sd1) >>> 1));
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			revb_pkg::ST_SM_MUL: begin
				mul_a = 33'(diff);
				mul_b = $signed({1'b0, cfg.coef});
			end
			revb_pkg::ST_FB_MUL: begin
				mul_a = $signed({16'd0, sm_val_q[0]});
				mul_b = $signed({10'd0, revb_pkg::FB_ROOM});
			end
			revb_pkg::ST_FB_SET: begin
				mul_a = $signed({16'd0, sm_val_q[1]});
				mul_b = $signed({10'd0, revb_pkg::DAMP_SCALE});
			end
			revb_pkg::ST_D_SET: begin
				mul_a = 33'(lr);
				mul_b = $signed({8'd0, revb_pkg::IN_GAIN});
			end
			revb_pkg::ST_CB_M1: begin
				mul_a = 33'($signed(c_rdata));
				mul_b = $signed({8'd0, one_m_d});
			end
			revb_pkg::ST_CB_M2: begin
				mul_a = 33'(lp_q[cb_q]);
				mul_b = $signed({10'd0, d_q});
			end
			revb_pkg::ST_CB_M3: begin
				mul_a = 33'(lp_q[cb_q]);
				mul_b = $signed({8'd0, fb_q});
			end
			revb_pkg::ST_WD_1: begin
				mul_a = 33'(al_q);
				mul_b = $signed({7'd0, wp});
			end
			revb_pkg::ST_WD_2: begin
				mul_a = 33'(ar_q);
				mul_b = $signed({8'd0, wm});
			end
			revb_pkg::ST_WD_3: begin
				mul_a = 33'(ar_q);
				mul_b = $signed({7'd0, wp});
			end
			revb_pkg::ST_WD_4: begin
				mul_a = 33'(al_q);
				mul_b = $signed({8'd0, wm});
			end
			revb_pkg::ST_WD_5: begin
				mul_a = 33'(l_q);
				mul_b = $signed({8'd0, mm});
			end
			revb_pkg::ST_WD_6: begin
				mul_a = 33'(wl_q);
				mul_b = $signed({8'd0, sm_val_q[3]});
			end
			revb_pkg::ST_WD_7: begin
				mul_a = 33'(r_q);
				mul_b = $signed({8'd0, mm});
			end
			revb_pkg::ST_WD_8: begin
				mul_a = 33'(wr_q);
				mul_b = $signed({8'd0, sm_val_q[3]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= revb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and status
	always_comb begin
		state_d        = state_q;
		stat.ready     = 1'b0;
		stat.res_valid = 1'b0;
		unique case (state_q)
			revb_pkg::ST_CLEAR: begin
				if (clr_q == 15'(revb_pkg::COMB_DEPTH - 1)) state_d = revb_pkg::ST_IDLE;
			end
			revb_pkg::ST_IDLE: begin
				stat.ready = 1'b1;
				if (start) state_d = revb_pkg::ST_SM_MUL;
			end
			revb_pkg::ST_SM_MUL:   state_d = revb_pkg::ST_SM_ADD;
			revb_pkg::ST_SM_ADD: begin
				state_d = (sm_q == 2'd3) ? revb_pkg::ST_FB_MUL : revb_pkg::ST_SM_MUL;
			end
			revb_pkg::ST_FB_MUL:   state_d = revb_pkg::ST_FB_SET;
			revb_pkg::ST_FB_SET:   state_d = revb_pkg::ST_D_SET;
			revb_pkg::ST_D_SET:    state_d = revb_pkg::ST_MONO_SET;
			revb_pkg::ST_MONO_SET: state_d = revb_pkg::ST_CB_RD;
			revb_pkg::ST_CB_RD:    state_d = revb_pkg::ST_CB_M1;
			revb_pkg::ST_CB_M1:    state_d = revb_pkg::ST_CB_M2;
			revb_pkg::ST_CB_M2:    state_d = revb_pkg::ST_CB_LP;
			revb_pkg::ST_CB_LP:    state_d = revb_pkg::ST_CB_M3;
			revb_pkg::ST_CB_M3:    state_d = revb_pkg::ST_CB_WR;
			revb_pkg::ST_CB_WR: begin
				state_d = (cb_q == 4'd15) ? revb_pkg::ST_AP_RD : revb_pkg::ST_CB_RD;
			end
			revb_pkg::ST_AP_RD:    state_d = revb_pkg::ST_AP_WR;
			revb_pkg::ST_AP_WR: begin
				state_d = (ap_q == 3'd7) ? revb_pkg::ST_WD_1 : revb_pkg::ST_AP_RD;
			end
			revb_pkg::ST_WD_1:     state_d = revb_pkg::ST_WD_2;
			revb_pkg::ST_WD_2:     state_d = revb_pkg::ST_WD_3;
			revb_pkg::ST_WD_3:     state_d = revb_pkg::ST_WD_4;
			revb_pkg::ST_WD_4:     state_d = revb_pkg::ST_WD_5;
			revb_pkg::ST_WD_5:     state_d = revb_pkg::ST_WD_6;
			revb_pkg::ST_WD_6:     state_d = revb_pkg::ST_WD_7;
			revb_pkg::ST_WD_7:     state_d = revb_pkg::ST_WD_8;
			revb_pkg::ST_WD_8:     state_d = revb_pkg::ST_WD_9;
			revb_pkg::ST_WD_9:     state_d = revb_pkg::ST_DONE;
			revb_pkg::ST_DONE: begin
				stat.res_valid = 1'b1;
				if (take) state_d = revb_pkg::ST_IDLE;
			end
			default:               state_d = revb_pkg::ST_CLEAR;
		endcase
	end

	// control state: counters, smoother, lowpass memories, line positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			sm_q        <= '0;
			cb_q        <= '0;
			ap_q        <= '0;
			first_q     <= 1'b0;
			sm_val_q[0] <= revb_pkg::RST_ROOM;
			sm_val_q[1] <= revb_pkg::RST_DAMP;
			sm_val_q[2] <= revb_pkg::RST_WIDTH;
			sm_val_q[3] <= revb_pkg::RST_MIX;
			for (int i = 0; i < 16; i++) begin
				lp_q[i]   <= '0;
				cpos_q[i] <= '0;
			end
			for (int i = 0; i < 8; i++) begin
				apos_q[i] <= '0;
			end
		end else begin
			if (clearing) clr_q <= clr_q + 15'd1;
			// first item after reset: smoothed values jump to targets
			if (state_q == revb_pkg::ST_IDLE && start && !first_q) begin
				first_q     <= 1'b1;
				sm_val_q[0] <= cfg.room;
				sm_val_q[1] <= cfg.damp;
				sm_val_q[2] <= cfg.width;
				sm_val_q[3] <= cfg.mix;
			end
			if (state_q == revb_pkg::ST_SM_ADD) begin
				sm_val_q[sm_q] <= 17'($signed({43'd0, sm_val_q[sm_q]})
					+ revb_pkg::rnd24(60'(prod_q)));
				sm_q <= sm_q + 2'd1;
			end
			if (state_q == revb_pkg::ST_CB_LP) begin
				lp_q[cb_q] <= revb_pkg::sat32(revb_pkg::rnd16(mac_sum));
			end
			if (state_q == revb_pkg::ST_CB_WR) begin
				cpos_q[cb_q] <= (cpos_inc == revb_pkg::COMB_LEN[cb_q]) ? '0 : cpos_inc;
				cb_q         <= cb_q + 4'd1;
			end
			if (state_q == revb_pkg::ST_AP_WR) begin
				apos_q[ap_q] <= (apos_inc == revb_pkg::AP_LEN[ap_q]) ? '0 : apos_inc;
				ap_q         <= ap_q + 3'd1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			revb_pkg::ST_IDLE: begin
				if (start) begin
					l_q <= frame.left_in;
					r_q <= frame.right_in;
				end
			end
			revb_pkg::ST_FB_SET: begin
				fb_q <= 17'(revb_pkg::rnd16(60'(prod_q)) + 60'(revb_pkg::FB_BASE));
			end
			revb_pkg::ST_D_SET: begin
				d_q <= 15'(revb_pkg::rnd16(60'(prod_q)));
			end
			revb_pkg::ST_MONO_SET: begin
				mono_q  <= 18'(revb_pkg::rnd24(60'(prod_q)));
				sum_l_q <= '0;
				sum_r_q <= '0;
			end
			revb_pkg::ST_CB_RD:    caddr_q <= cb_addr;
			revb_pkg::ST_CB_M1: begin
				if (cb_q[3]) sum_r_q <= sum_r_q + 35'($signed(c_rdata));
				else         sum_l_q <= sum_l_q + 35'($signed(c_rdata));
			end
			revb_pkg::ST_CB_M2:    acc_q <= prod_q;
			revb_pkg::ST_CB_WR: begin
				if (cb_q == 4'd15) begin
					al_q <= revb_pkg::sat32(60'(sum_l_q));
					ar_q <= revb_pkg::sat32(60'(sum_r_q));
				end
			end
			revb_pkg::ST_AP_RD:    aaddr_q <= ap_addr;
			revb_pkg::ST_AP_WR: begin
				if (ap_q[2]) ar_q <= ap_y;
				else         al_q <= ap_y;
			end
			revb_pkg::ST_WD_2, revb_pkg::ST_WD_4,
			revb_pkg::ST_WD_6, revb_pkg::ST_WD_8: acc_q <= prod_q;
			revb_pkg::ST_WD_3:     wl_q <= revb_pkg::sat32(revb_pkg::rnd17(mac_sum));
			revb_pkg::ST_WD_5:     wr_q <= revb_pkg::sat32(revb_pkg::rnd17(mac_sum));
			revb_pkg::ST_WD_7:     ol_q <= revb_pkg::sat24(revb_pkg::rnd16(mac_sum));
			revb_pkg::ST_WD_9:     or_q <= revb_pkg::sat24(revb_pkg::rnd16(mac_sum));
			default: begin
			end
		endcase
	end

	assign result.left_out  = ol_q;
	assign result.right_out = or_q;

endmodule
`default_nettype wire

>>> hw/rtl/stereo_comb_allpass_reverb_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb_unit: stereo comb/allpass reverb, top level
// Config registers, input handshake and output register around the core.
// ----------------------------------------------------------------------------
//  channel   signals                         moves
//  dry       dry_valid, dry_stall, dry_frame one stereo input item
//  wet       wet_valid, wet_stall, wet_frame one stereo result item
//  cfg       cfg_we, cfg_index, cfg_data     register write, no wait
//
//  One item at a time: parameter glide, coefficients, then per comb line
//  (16 lines) read, lowpass and feedback write-back, per allpass line
//  (8 lines) read and write, then width and mix, all on one shared multiplier.
//  After reset a clearing pass zeroes the delay RAMs; dry_stall stays high
//  meanwhile. A result still in the core while the output register is full
//  and stalled blocks the next item from being taken.
// ----------------------------------------------------------------------------
module stereo_comb_allpass_reverb_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                dry_valid,
	output logic                     dry_stall,
	input  wire revb_pkg::revb_in_t  dry_frame,
	output logic                     wet_valid,
	input  wire logic                wet_stall,
	output revb_pkg::revb_out_t      wet_frame,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [23:0]         cfg_data
);

	revb_pkg::revb_cfg_t  cfg_q;
	revb_pkg::revb_stat_t stat;
	revb_pkg::revb_out_t  result;
	revb_pkg::revb_out_t  wet_frame_q;
	logic                 wet_valid_q;
	logic                 start;
	logic                 take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.room  <= revb_pkg::RST_ROOM;
			cfg_q.damp  <= revb_pkg::RST_DAMP;
			cfg_q.width <= revb_pkg::RST_WIDTH;
			cfg_q.mix   <= revb_pkg::RST_MIX;
			cfg_q.coef  <= revb_pkg::RST_COEF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				revb_pkg::CFG_ROOM:  cfg_q.room  <= revb_pkg::clamp_one(cfg_data);
				revb_pkg::CFG_DAMP:  cfg_q.damp  <= revb_pkg::clamp_one(cfg_data);
				revb_pkg::CFG_WIDTH: cfg_q.width <= revb_pkg::clamp_one(cfg_data);
				revb_pkg::CFG_MIX:   cfg_q.mix   <= revb_pkg::clamp_one(cfg_data);
				revb_pkg::CFG_COEF:  cfg_q.coef  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// handshakes
	assign dry_stall = !stat.ready;
	assign start     = dry_valid && stat.ready;
	assign take      = stat.res_valid && (!wet_valid_q || !wet_stall);

	revb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.frame  (dry_frame),
		.cfg    (cfg_q),
		.take   (take),
		.stat   (stat),
		.result (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_valid_q <= 1'b0;
		end else if (take) begin
			wet_valid_q <= 1'b1;
		end else if (!wet_stall) begin
			wet_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) wet_frame_q <= result;
	end

	assign wet_valid = wet_valid_q;
	assign wet_frame = wet_frame_q;

endmodule
`default_nettype wire

>>> hw/rtl/revb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// revb_checker: port-level checks of the reverb unit
// Watches the handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
module revb_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                dry_valid,
	input wire logic                dry_stall,
	input wire revb_pkg::revb_in_t  dry_frame,
	input wire logic                wet_valid,
	input wire logic                wet_stall,
	input wire revb_pkg::revb_out_t wet_frame,
	input wire logic                cfg_we,
	input wire logic [2:0]          cfg_index,
	input wire logic [23:0]         cfg_data
);

	logic dry_take;
	assign dry_take = dry_valid && !dry_stall;

	// stalled result holds
	a_wet_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wet_valid && wet_stall |=> wet_valid && $stable(wet_frame))
		else $error("wet item changed while stalled");

	// stalled input item holds
	a_dry_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dry_valid && dry_stall |=> dry_valid && $stable(dry_frame))
		else $error("dry item changed while stalled");

	// one item in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dry_take |=> dry_stall)
		else $error("second item taken while busy");

	// a new result is handed over only from the busy sequencer
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wet_valid) |-> $past(dry_stall))
		else $error("result appeared while idle");

	// register writes are known and land while the sequencer is idle
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !dry_stall && !$isunknown({cfg_index, cfg_data}))
		else $error("register write while busy or unknown");

endmodule

bind stereo_comb_allpass_reverb_unit revb_checker u_revb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.dry_valid (dry_valid),
	.dry_stall (dry_stall),
	.dry_frame (dry_frame),
	.wet_valid (wet_valid),
	.wet_stall (wet_stall),
	.wet_frame (wet_frame),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the stereo comb/allpass reverb unit
// Drives stereo frames through the handshake and compares every output
// frame against a bit-exact predictor with its own delay lines and glide.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic dry_valid = 1'b0;
	logic dry_stall;
	revb_pkg::revb_in_t dry_frame = '0;
	logic wet_valid;
	logic wet_stall = 1'b0;
	revb_pkg::revb_out_t wet_frame;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	stereo_comb_allpass_reverb_unit dut (
		.clk(clk), .arst_n(arst_n),
		.dry_valid(dry_valid), .dry_stall(dry_stall), .dry_frame(dry_frame),
		.wet_valid(wet_valid), .wet_stall(wet_stall), .wet_frame(wet_frame),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Predictor state
	int comb_mem [revb_pkg::COMB_DEPTH];
	int ap_mem [revb_pkg::AP_DEPTH];
	int comb_pos [16];
	int ap_pos [8];
	int comb_lp [16];
	longint sm_room, sm_damp, sm_width, sm_mix;
	bit primed;
	longint reg_room, reg_damp, reg_width, reg_mix, reg_coef;

	revb_pkg::revb_out_t wet_expected [$];
	bit failed = 1'b0;
	bit tail_phase = 1'b0;
	bit long_hold = 1'b0;
	int idle_cycles = 0;
	int stall_left = 0;

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clip24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic longint unit_clamp(logic [23:0] v);
		return (v[16:0] > 17'd65536) ? 65536 : longint'(v[16:0]);
	endfunction

	function automatic longint glide_step(longint s, longint target);
		return s + round_shift((target - s) * reg_coef, 24);
	endfunction

	task automatic predictor_reset();
		foreach (comb_mem[i]) comb_mem[i] = 0;
		foreach (ap_mem[i]) ap_mem[i] = 0;
		foreach (comb_pos[i]) begin
			comb_pos[i] = 0;
			comb_lp[i] = 0;
		end
		foreach (ap_pos[i]) ap_pos[i] = 0;
		sm_room = 32768; sm_damp = 32768; sm_width = 65536; sm_mix = 19661;
		primed = 1'b0;
		reg_room = 32768; reg_damp = 32768; reg_width = 65536; reg_mix = 19661;
		reg_coef = 34917;
	endtask

	task automatic predict_reverb(revb_pkg::revb_in_t f);
		longint l, r, fb, dmp, mono, sum_l, sum_r, y, lp, b, w, m, wl, wr;
		longint al, ar, x;
		int at, p;
		revb_pkg::revb_out_t o;
		l = f.left_in;
		r = f.right_in;
		if (!primed) begin
			sm_room = reg_room; sm_damp = reg_damp;
			sm_width = reg_width; sm_mix = reg_mix;
			primed = 1'b1;
		end
		sm_room = glide_step(sm_room, reg_room);
		sm_damp = glide_step(sm_damp, reg_damp);
		sm_width = glide_step(sm_width, reg_width);
		sm_mix = glide_step(sm_mix, reg_mix);
		fb = 45875 + round_shift(sm_room * 18350, 16);
		dmp = round_shift(sm_damp * 26214, 16);
		mono = round_shift((l + r) * 125829, 24);
		sum_l = 0;
		sum_r = 0;
		// parallel damped combs
		for (int k = 0; k < 16; k++) begin
			p = comb_pos[k];
			at = revb_pkg::COMB_BASE[k] + p;
			y = comb_mem[at];
			lp = round_shift(y * (65536 - dmp) + longint'(comb_lp[k]) * dmp, 16);
			comb_lp[k] = int'(clip32(lp));
			comb_mem[at] = int'(clip32(mono + round_shift(longint'(comb_lp[k]) * fb, 16)));
			comb_pos[k] = (p + 1 < revb_pkg::COMB_LEN[k]) ? p + 1 : 0;
			if (k < 8) sum_l += y; else sum_r += y;
		end
		al = clip32(sum_l);
		ar = clip32(sum_r);
		// series allpasses, left line k and right line k+4
		for (int k = 0; k < 8; k++) begin
			x = (k < 4) ? al : ar;
			p = ap_pos[k];
			at = revb_pkg::AP_BASE[k] + p;
			b = ap_mem[at];
			y = clip32(b - x);
			ap_mem[at] = int'(clip32(x + round_shift(b, 1)));
			ap_pos[k] = (p + 1 < revb_pkg::AP_LEN[k]) ? p + 1 : 0;
			if (k < 4) al = y; else ar = y;
		end
		w = sm_width;
		m = sm_mix;
		wl = clip32(round_shift((65536 + w) * al + (65536 - w) * ar, 17));
		wr = clip32(round_shift((65536 + w) * ar + (65536 - w) * al, 17));
		o.left_out = 24'(clip24(round_shift(l * (65536 - m) + wl * m, 16)));
		o.right_out = 24'(clip24(round_shift(r * (65536 - m) + wr * m, 16)));
		wet_expected.push_back(o);
	endtask

	// Send one frame, predicting at acceptance; valid stays up until the
	// next gap or drain
	task automatic send_frame(logic signed [23:0] lv, logic signed [23:0] rv, bit gaps);
		revb_pkg::revb_in_t f;
		if (gaps && !tail_phase && $urandom_range(0, 3) == 0) begin
			dry_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		f.left_in = lv;
		f.right_in = rv;
		dry_valid <= 1'b1;
		dry_frame <= f;
		@(posedge clk);
		while (dry_stall) @(posedge clk);
		predict_reverb(f);
	endtask

	task automatic wait_drained();
		dry_valid <= 1'b0;
		while (wet_expected.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(revb_pkg::revb_cfg_idx_t idx, logic [23:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			revb_pkg::CFG_ROOM:  reg_room = unit_clamp(v);
			revb_pkg::CFG_DAMP:  reg_damp = unit_clamp(v);
			revb_pkg::CFG_WIDTH: reg_width = unit_clamp(v);
			revb_pkg::CFG_MIX:   reg_mix = unit_clamp(v);
			revb_pkg::CFG_COEF:  reg_coef = v;
			default: ;
		endcase
	endtask

	task automatic random_audio(int n, bit gaps);
		logic signed [23:0] lv, rv;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: begin
					lv = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
					rv = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
				end
				1: begin
					lv = 24'($signed(12'($urandom)));
					rv = 24'($signed(12'($urandom)));
				end
				default: begin
					lv = 24'($urandom);
					rv = 24'($urandom);
				end
			endcase
			send_frame(lv, rv, gaps);
		end
	endtask

	// First frame loads, full-scale extremes, silence, opposite polarity
	task automatic test_directed();
		send_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
		send_frame(24'sh800000, 24'sh800000, 1'b0);
		send_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
		send_frame(24'sh000000, 24'sh000000, 1'b0);
		send_frame(24'sh000001, 24'shFFFFFF, 1'b0);
		for (int i = 0; i < 15; i++)
			send_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
		wait_drained();
	endtask

	// Register extremes, above-one saturation, unknown index, zero coefficient
	task automatic test_settings();
		write_reg(revb_pkg::CFG_ROOM, 24'd65536);
		write_reg(revb_pkg::CFG_DAMP, 24'd0);
		write_reg(revb_pkg::CFG_WIDTH, 24'd0);
		write_reg(revb_pkg::CFG_MIX, 24'd65536);
		write_reg(revb_pkg::CFG_COEF, 24'hFFFFFF);
		random_audio(300, 1'b1);
		wait_drained();
		write_reg(revb_pkg::CFG_ROOM, 24'hFFFFFF);
		write_reg(revb_pkg::CFG_DAMP, 24'd131071);
		write_reg(revb_pkg::CFG_WIDTH, 24'd70000);
		write_reg(revb_pkg::CFG_MIX, 24'd0);
		write_reg(revb_pkg::CFG_COEF, 24'd0);
		cfg_we <= 1'b1;
		cfg_index <= 3'd7;
		cfg_data <= 24'hFFFFFF;
		@(posedge clk);
		cfg_we <= 1'b0;
		random_audio(300, 1'b1);
		wait_drained();
		write_reg(revb_pkg::CFG_ROOM, 24'd0);
		write_reg(revb_pkg::CFG_DAMP, 24'd65536);
		write_reg(revb_pkg::CFG_WIDTH, 24'd32768);
		write_reg(revb_pkg::CFG_MIX, 24'd40000);
		write_reg(revb_pkg::CFG_COEF, 24'd34917);
		random_audio(300, 1'b1);
		wait_drained();
	endtask

	// Receiver holds off while frames keep coming, then sender pauses
	task automatic test_backpressure();
		long_hold = 1'b1;
		fork
			begin
				repeat (2000) @(posedge clk);
				long_hold = 1'b0;
			end
			random_audio(30, 1'b0);
		join
		wait_drained();
	endtask

	task automatic test_random();
		for (int i = 0; i < 4; i++) begin
			write_reg(revb_pkg::CFG_ROOM, 24'($urandom_range(0, 70000)));
			write_reg(revb_pkg::CFG_DAMP, 24'($urandom_range(0, 70000)));
			write_reg(revb_pkg::CFG_WIDTH, 24'($urandom_range(0, 70000)));
			write_reg(revb_pkg::CFG_MIX, 24'($urandom_range(0, 70000)));
			write_reg(revb_pkg::CFG_COEF, 24'($urandom_range(0, 24'hFFFFFF)));
			random_audio(250, 1'b1);
			wait_drained();
		end
		tail_phase = 1'b1;
		random_audio(100, 1'b0);
	endtask

	// Random receiver stall bursts; held high during long_hold, off in the tail phase
	always @(posedge clk) begin
		if (long_hold) wet_stall <= 1'b1;
		else if (tail_phase) wet_stall <= 1'b0;
		else if (stall_left > 0) stall_left <= stall_left - 1;
		else if (wet_stall) wet_stall <= 1'b0;
		else if ($urandom_range(0, 7) == 0) begin
			wet_stall <= 1'b1;
			stall_left <= $urandom_range(0, 10);
		end
	end

	// Output checker and watchdog
	always @(posedge clk) begin
		revb_pkg::revb_out_t e;
		if (arst_n) begin
			if ((dry_valid && !dry_stall) || (wet_valid && !wet_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > LIMIT) begin
				$display("stereo_comb_allpass_reverb_unit regression: fail");
				$finish;
			end
			if (wet_valid && !wet_stall) begin
				if (wet_expected.size() == 0) begin
					$error("unexpected output frame");
					failed = 1'b1;
				end else begin
					e = wet_expected.pop_front();
					if (wet_frame.left_out !== e.left_out) begin
						$error("left_out expected %0d actual %0d", e.left_out,
							wet_frame.left_out);
						failed = 1'b1;
					end
					if (wet_frame.right_out !== e.right_out) begin
						$error("right_out expected %0d actual %0d", e.right_out,
							wet_frame.right_out);
						failed = 1'b1;
					end
				end
			end
		end
	end

	initial begin
		predictor_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_settings();
		test_backpressure();
		test_random();
		wait_drained();
		if (!failed && wet_expected.size() == 0)
			$display("stereo_comb_allpass_reverb_unit regression: pass");
		else
			$display("stereo_comb_allpass_reverb_unit regression: fail");
		$finish;
	end

endmodule
